FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bdq_pkg.sv
// Request and status codes of the deque.
`default_nettype none

package bdq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_HEAD = 3'd0,
    REQ_PUSH_TAIL = 3'd1,
    REQ_POP_HEAD  = 3'd2,
    REQ_POP_TAIL  = 3'd3,
    REQ_INSERT    = 3'd4,
    REQ_DELETE    = 3'd5,
    REQ_GET       = 3'd6,
    REQ_FIND      = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bounded_deque_with_positional_edit.sv
// Top level: bounded deque with positional insert, delete, get and find.
//
//  channel | direction | fields                                     | handshake
//  in      | input     | req_type, position, entry_in               | in_valid / in_ready
//  out     | output    | status, entry_out, found_index, fill_count | out_valid / out_ready
//
// Pushes and refused requests go straight from IDLE to DONE; pops and gets read one word in SCAN;
// insert and delete move or read their N words in SCAN, one slot a cycle;
// find reads the words in order and stops at the first match, else scans all N words.
// Reset empties the window and puts the start at CAP/4; slots are not cleared.
// One result can wait at the outputs while the next request runs; a second finished one
// holds the block in its final state with in_ready low until out_ready takes the first.
`default_nettype none

module bounded_deque_with_positional_edit #(
  parameter int CAP         = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] entry_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      entry_out,
  output logic [5:0]       found_index,
  output logic [6:0]       fill_count
);

  localparam int AW = $clog2(CAP);
  localparam int CW = AW + 1;
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int EW = ENTRY_WIDTH;
  localparam logic [CW-1:0] CAP_W     = CW'(CAP);
  localparam logic [AW-1:0] START_RST = AW'(CAP / 4);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAP - 1);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t              state;
  logic [AW-1:0]       start;
  logic [CW-1:0]       count;
  bdq_pkg::req_t       op;
  logic [EW-1:0]       val;
  logic [AW-1:0]       rd_ptr;
  logic [AW-1:0]       wr_ptr;
  logic [AW-1:0]       ins_addr;
  logic [CW-1:0]       left;
  logic                pend;
  logic                first;
  logic [AW-1:0]       nidx;
  logic [AW-1:0]       pidx;
  bdq_pkg::status_t    res_status;
  logic [EW-1:0]       res_entry;
  logic [AW-1:0]       res_idx;

  logic [EW-1:0]       mem [CAP];
  logic [EW-1:0]       rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [EW-1:0]       mem_wd;
  logic                mem_re;

  bdq_pkg::req_t       req;
  logic [EW-1:0]       in_val;
  logic [CW-1:0]       end_w;
  logic [AW-1:0]       end_m1;
  logic [PW-1:0]       pos_x;
  logic [PW-1:0]       count_x;
  logic                pos_ok;
  logic [CW-1:0]       pos_cw;
  logic [CW-1:0]       pos_c;
  logic [AW-1:0]       pos_addr;

  assign in_ready = (state == IDLE);
  assign req      = bdq_pkg::req_t'(req_type);
  assign in_val   = EW'(entry_in);
  assign end_w    = CW'(start) + count;
  assign end_m1   = AW'(end_w - 1'b1);
  assign pos_x    = PW'(position);
  assign count_x  = PW'(count);
  assign pos_ok   = pos_x < count_x;
  assign pos_cw   = CW'(pos_x);
  // insert past the end appends
  assign pos_c    = (pos_x > count_x) ? count : pos_cw;
  assign pos_addr = AW'(CW'(start) + pos_cw);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_ptr;
    mem_wd = rd_data;
    mem_re = (state == SCAN) && (left != '0);
    case (state)
      IDLE: begin
        if (in_valid && req == bdq_pkg::REQ_PUSH_HEAD && start != '0) begin
          mem_we = 1'b1;
          mem_wa = start - 1'b1;
          mem_wd = in_val;
        end else if (in_valid && req == bdq_pkg::REQ_PUSH_TAIL && end_w < CAP_W) begin
          mem_we = 1'b1;
          mem_wa = AW'(end_w);
          mem_wd = in_val;
        end
      end
      SCAN: begin
        if (pend && (op == bdq_pkg::REQ_INSERT || (op == bdq_pkg::REQ_DELETE && !first))) begin
          // move the word read last cycle one slot over
          mem_we = 1'b1;
          mem_wa = wr_ptr;
          mem_wd = rd_data;
        end else if (!pend && left == '0 && op == bdq_pkg::REQ_INSERT) begin
          mem_we = 1'b1;
          mem_wa = ins_addr;
          mem_wd = val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      start     <= START_RST;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) begin
            op         <= req;
            val        <= in_val;
            res_status <= bdq_pkg::ST_OK;
            res_entry  <= '0;
            res_idx    <= '0;
            rd_ptr     <= start;
            left       <= '0;
            pend       <= 1'b0;
            first      <= 1'b1;
            nidx       <= '0;
            state      <= SCAN;
            case (req)
              bdq_pkg::REQ_PUSH_HEAD: begin
                if (start == '0) begin
                  res_status <= bdq_pkg::ST_NO_ROOM;
                end else begin
                  start <= start - 1'b1;
                  count <= count + 1'b1;
                end
                state <= DONE;
              end
              bdq_pkg::REQ_PUSH_TAIL: begin
                if (end_w >= CAP_W) res_status <= bdq_pkg::ST_NO_ROOM;
                else count <= count + 1'b1;
                state <= DONE;
              end
              bdq_pkg::REQ_POP_HEAD: begin
                if (count == '0) begin
                  res_status <= bdq_pkg::ST_EMPTY;
                  state      <= DONE;
                end else begin
                  left  <= CW'(1);
                  start <= (start == LAST_SLOT) ? '0 : start + 1'b1;
                  count <= count - 1'b1;
                end
              end
              bdq_pkg::REQ_POP_TAIL: begin
                if (count == '0) begin
                  res_status <= bdq_pkg::ST_EMPTY;
                  state      <= DONE;
                end else begin
                  rd_ptr <= end_m1;
                  left   <= CW'(1);
                  count  <= count - 1'b1;
                end
              end
              bdq_pkg::REQ_INSERT: begin
                if (end_w >= CAP_W) begin
                  res_status <= bdq_pkg::ST_NO_ROOM;
                  state      <= DONE;
                end else begin
                  // walk down from the tail, moving each word up one slot
                  rd_ptr   <= end_m1;
                  left     <= count - pos_c;
                  ins_addr <= AW'(CW'(start) + pos_c);
                  count    <= count + 1'b1;
                end
              end
              bdq_pkg::REQ_DELETE: begin
                if (!pos_ok) begin
                  res_status <= bdq_pkg::ST_BAD_POS;
                  state      <= DONE;
                end else begin
                  // first read is the removed word, the rest move down one slot
                  rd_ptr <= pos_addr;
                  left   <= count - pos_cw;
                  count  <= count - 1'b1;
                end
              end
              bdq_pkg::REQ_GET: begin
                if (!pos_ok) begin
                  res_status <= bdq_pkg::ST_BAD_POS;
                  state      <= DONE;
                end else begin
                  rd_ptr <= pos_addr;
                  left   <= CW'(1);
                end
              end
              bdq_pkg::REQ_FIND: begin
                left       <= count;
                res_status <= bdq_pkg::ST_NOT_FOUND;
              end
              default: state <= DONE;
            endcase
          end
        end
        SCAN: begin
          if (left != '0) begin
            pend <= 1'b1;
            left <= left - 1'b1;
            pidx <= nidx;
            nidx <= nidx + 1'b1;
            if (op == bdq_pkg::REQ_INSERT) begin
              wr_ptr <= rd_ptr + 1'b1;
              rd_ptr <= rd_ptr - 1'b1;
            end else begin
              wr_ptr <= rd_ptr - 1'b1;
              rd_ptr <= rd_ptr + 1'b1;
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            first <= 1'b0;
            if (op == bdq_pkg::REQ_FIND) begin
              if (rd_data == val) begin
                res_status <= bdq_pkg::ST_OK;
                res_idx    <= pidx;
                state      <= DONE;
              end
            end else if (op != bdq_pkg::REQ_INSERT && first) begin
              res_entry <= rd_data;
            end
          end
          if (left == '0 && !pend) state <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            status      <= res_status;
            entry_out   <= 32'(res_entry);
            found_index <= 6'(res_idx);
            fill_count  <= 7'(count);
            out_valid   <= 1'b1;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bdq_checker.sv
// Port-level checker for the deque, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module bdq_checker #(
  parameter int CAP = 64
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [31:0] entry_out,
  input wire logic [5:0]  found_index,
  input wire logic [6:0]  fill_count
);

  `ASSERT_IMPLIES(a_fill_bound, out_valid, fill_count <= CAP)
  `ASSERT_IMPLIES(a_fail_no_entry, out_valid && status != bdq_pkg::ST_OK, entry_out == '0)
  `ASSERT_IMPLIES(a_fail_no_index, out_valid && status != bdq_pkg::ST_OK, found_index == '0)
  `ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

endmodule

bind bounded_deque_with_positional_edit bdq_checker #(.CAP(CAP)) u_bdq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .entry_out   (entry_out),
  .found_index (found_index),
  .fill_count  (fill_count)
);

`default_nettype wire
